>>> sv/gtt_pkg.sv
// gtt_pkg: shared types, constants and codes of the grid threshold triangulator.
// Used by every module of the block but gtt_ram; depends on nothing.
package gtt_pkg;

    localparam int GTT_MAX_COLUMNS     = 1024;
    localparam int GTT_NUM_CONSTRAINTS = 2;
    localparam int GTT_ID_W            = 20;
    localparam int GTT_ROW_LEN_W       = 11;
    localparam int GTT_VALUE_W         = 32;
    localparam int GTT_CFG_IDX_W       = 3;
    localparam int GTT_CFG_DATA_W      = 32;
    localparam int GTT_QUEUE_DEPTH     = 4;
    localparam int GTT_QPTR_W          = $clog2(GTT_QUEUE_DEPTH);
    localparam int GTT_QCOUNT_W        = $clog2(GTT_QUEUE_DEPTH + 1);

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [GTT_CFG_IDX_W-1:0] {
        CFG_ROW_LENGTH,
        CFG_THRESHOLD_ENABLE,
        CFG_TRIANGLE_ENABLE,
        CFG_CONSTRAINT_MASK,
        CFG_LOWER_A,
        CFG_UPPER_A,
        CFG_LOWER_B,
        CFG_UPPER_B
    } t_cfg_idx;

    typedef enum logic [2:0] {
        TRI_NONE,
        TRI_PAIR,
        TRI_AL_A_L,
        TRI_AL_A_C,
        TRI_AL_C_L,
        TRI_A_C_L
    } t_tri_mode;

    typedef logic [GTT_ID_W-1:0] t_id;

    typedef struct packed {
        logic [GTT_ROW_LEN_W-1:0] row_length;
        logic                     threshold_enable;
        logic                     triangle_enable;
        logic [1:0]               constraint_mask;
        logic [GTT_VALUE_W-1:0]   lower_a;
        logic [GTT_VALUE_W-1:0]   upper_a;
        logic [GTT_VALUE_W-1:0]   lower_b;
        logic [GTT_VALUE_W-1:0]   upper_b;
    } t_cfg;

    localparam t_cfg GTT_CFG_RESET = '{
        row_length:       11'd1024,
        threshold_enable: 1'b0,
        triangle_enable:  1'b0,
        constraint_mask:  2'd0,
        lower_a:          32'h8000_0000,
        upper_a:          32'h7FFF_FFFF,
        lower_b:          32'h8000_0000,
        upper_b:          32'h7FFF_FFFF
    };

    typedef struct packed {
        t_id       id;
        t_id       id_l;
        t_id       id_a;
        t_id       id_al;
        logic      has_vtx;
        t_tri_mode mode;
    } t_rec;

endpackage

>>> sv/gtt_ram.sv
// gtt_ram: generic simple dual-port RAM, one write port, one registered read port.
// Read returns the old data on a same-address write. No dependencies.
module gtt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/gtt_front.sv
// gtt_front: accepts points, thresholds them, keeps the grid counters and the
// validity line buffer, and classifies each point into a queue record.
// Depends on gtt_pkg and gtt_ram.
module gtt_front #(
    parameter int MAX_COLUMNS = gtt_pkg::GTT_MAX_COLUMNS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gtt_pkg::t_cfg                       i_cfg,
    input  logic                                i_push,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_a,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_b,
    input  logic                                i_frame_start,
    output logic                                o_full,
    input  logic [gtt_pkg::GTT_QCOUNT_W-1:0]    i_q_count,
    output logic                                o_q_push,
    output gtt_pkg::t_rec                       o_q_rec
);

    localparam int CW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LW = ((CW > gtt_pkg::GTT_ROW_LEN_W) ? CW : gtt_pkg::GTT_ROW_LEN_W) + 1;
    localparam logic [LW-1:0] MaxCols = LW'(MAX_COLUMNS);
    localparam int FW = gtt_pkg::GTT_QCOUNT_W + 1;

    logic                 accept;
    logic [LW-1:0]        rlen_raw;
    logic [LW-1:0]        rlen;
    logic [CW-1:0]        col_eff;
    logic [CW-1:0]        col;
    logic                 row_end;
    gtt_pkg::t_id         id;
    logic                 row_nz;
    logic                 lf;
    logic                 cur;
    logic                 ab;
    gtt_pkg::t_tri_mode   mode;

    logic [CW-1:0]        r_col;
    logic                 r_row_nz;
    logic                 r_left;
    gtt_pkg::t_id         r_point;
    logic                 r_s1_valid;
    logic                 r_last_ab;
    gtt_pkg::t_id         r_s1_id;
    gtt_pkg::t_id         r_s1_id_l;
    gtt_pkg::t_id         r_s1_id_a;
    gtt_pkg::t_id         r_s1_id_al;
    logic                 r_s1_cur;
    logic                 r_s1_lf;
    logic                 r_s1_tri_ok;

    assign o_full = (FW'(i_q_count) + FW'(r_s1_valid)) >= FW'(gtt_pkg::GTT_QUEUE_DEPTH);
    assign accept = i_push && !o_full;

    always_comb begin
        rlen_raw = LW'(i_cfg.row_length);
        if (rlen_raw < LW'(2)) begin
            rlen = LW'(2);
        end else if (rlen_raw > MaxCols) begin
            rlen = MaxCols;
        end else begin
            rlen = rlen_raw;
        end

        col_eff = i_frame_start ? '0 : r_col;
        col     = (LW'(col_eff) >= rlen) ? '0 : col_eff;
        row_end = (LW'(col) + LW'(1)) >= rlen;
        id      = i_frame_start ? '0 : r_point;
        row_nz  = !i_frame_start && r_row_nz;
        lf      = !i_frame_start && r_left;

        cur = 1'b1;
        if (i_cfg.threshold_enable) begin
            if (gtt_pkg::GTT_NUM_CONSTRAINTS > 0 && i_cfg.constraint_mask[0] &&
                (i_value_a < $signed(i_cfg.lower_a) ||
                 $signed(i_cfg.upper_a) < i_value_a)) begin
                cur = 1'b0;
            end
            if (gtt_pkg::GTT_NUM_CONSTRAINTS > 1 && i_cfg.constraint_mask[1] &&
                (i_value_b < $signed(i_cfg.lower_b) ||
                 $signed(i_cfg.upper_b) < i_value_b)) begin
                cur = 1'b0;
            end
        end
    end

    gtt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (col),
        .i_wdata (cur),
        .i_raddr (col),
        .o_rdata (ab)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row_nz   <= 1'b0;
            r_left     <= 1'b0;
            r_point    <= '0;
            r_s1_valid <= 1'b0;
            r_last_ab  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col    <= row_end ? '0 : col + CW'(1);
                r_left   <= row_end ? 1'b0 : cur;
                r_row_nz <= row_nz || row_end;
                r_point  <= id + gtt_pkg::t_id'(1);
            end
            if (r_s1_valid) begin
                r_last_ab <= ab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_id     <= id;
            r_s1_id_l   <= id - gtt_pkg::t_id'(1);
            r_s1_id_a   <= id - gtt_pkg::t_id'(rlen);
            r_s1_id_al  <= id - gtt_pkg::t_id'(rlen) - gtt_pkg::t_id'(1);
            r_s1_cur    <= cur;
            r_s1_lf     <= lf;
            r_s1_tri_ok <= i_cfg.triangle_enable && row_nz && (col != '0);
        end
    end

    always_comb begin
        mode = gtt_pkg::TRI_NONE;
        if (r_s1_tri_ok) begin
            if (r_last_ab && ab && r_s1_lf && r_s1_cur) begin
                mode = gtt_pkg::TRI_PAIR;
            end else if (r_last_ab && ab && r_s1_lf) begin
                mode = gtt_pkg::TRI_AL_A_L;
            end else if (r_last_ab && ab && r_s1_cur) begin
                mode = gtt_pkg::TRI_AL_A_C;
            end else if (r_last_ab && r_s1_lf && r_s1_cur) begin
                mode = gtt_pkg::TRI_AL_C_L;
            end else if (ab && r_s1_lf && r_s1_cur) begin
                mode = gtt_pkg::TRI_A_C_L;
            end
        end
        o_q_push        = r_s1_valid && (r_s1_cur || mode != gtt_pkg::TRI_NONE);
        o_q_rec.id      = r_s1_id;
        o_q_rec.id_l    = r_s1_id_l;
        o_q_rec.id_a    = r_s1_id_a;
        o_q_rec.id_al   = r_s1_id_al;
        o_q_rec.has_vtx = r_s1_cur;
        o_q_rec.mode    = mode;
    end

endmodule

>>> sv/gtt_queue.sv
// gtt_queue: short register FIFO of classified point records between front and back.
// Depends on gtt_pkg.
module gtt_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  gtt_pkg::t_rec                    i_data,
    input  logic                             i_pop,
    output gtt_pkg::t_rec                    o_data,
    output logic                             o_empty,
    output logic [gtt_pkg::GTT_QCOUNT_W-1:0] o_count
);

    localparam int PW = gtt_pkg::GTT_QPTR_W;
    localparam logic [PW-1:0] LastPtr = PW'(gtt_pkg::GTT_QUEUE_DEPTH - 1);

    gtt_pkg::t_rec                    r_mem [gtt_pkg::GTT_QUEUE_DEPTH];
    logic [PW-1:0]                    r_wr_ptr;
    logic [PW-1:0]                    r_rd_ptr;
    logic [gtt_pkg::GTT_QCOUNT_W-1:0] r_count;
    logic                             do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + gtt_pkg::GTT_QCOUNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - gtt_pkg::GTT_QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/gtt_back.sv
// gtt_back: expands one queued record into its vertex and triangle results,
// one per cycle, held on the result ports until popped. Depends on gtt_pkg.
module gtt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  gtt_pkg::t_rec       i_q_data,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_kind,
    output gtt_pkg::t_id        o_vertex_first,
    output gtt_pkg::t_id        o_vertex_second,
    output gtt_pkg::t_id        o_vertex_third,
    output logic                o_last
);

    logic          r_busy;
    logic [1:0]    r_step;
    gtt_pkg::t_rec r_rec;
    logic [1:0]    ntri;
    logic [1:0]    nres;
    logic [1:0]    tidx;
    logic          load;

    always_comb begin
        unique case (r_rec.mode)
            gtt_pkg::TRI_NONE: ntri = 2'd0;
            gtt_pkg::TRI_PAIR: ntri = 2'd2;
            default:           ntri = 2'd1;
        endcase
        nres   = ntri + 2'(r_rec.has_vtx);
        tidx   = r_step - 2'(r_rec.has_vtx);
        o_last = (r_step == nres - 2'd1);
    end

    assign o_empty = !r_busy;
    assign load    = (!r_busy || (i_pop && o_last)) && !i_q_empty;
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (i_pop && r_busy) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_data;
        end
    end

    always_comb begin
        o_kind          = gtt_pkg::KIND_TRIANGLE;
        o_vertex_first  = '0;
        o_vertex_second = '0;
        o_vertex_third  = '0;
        if (r_rec.has_vtx && r_step == 2'd0) begin
            o_kind         = gtt_pkg::KIND_VERTEX;
            o_vertex_first = r_rec.id;
        end else begin
            unique case (r_rec.mode)
                gtt_pkg::TRI_PAIR: begin
                    o_vertex_first = r_rec.id_al;
                    if (tidx == 2'd0) begin
                        o_vertex_second = r_rec.id_a;
                        o_vertex_third  = r_rec.id;
                    end else begin
                        o_vertex_second = r_rec.id;
                        o_vertex_third  = r_rec.id_l;
                    end
                end
                gtt_pkg::TRI_AL_A_L: begin
                    o_vertex_first  = r_rec.id_al;
                    o_vertex_second = r_rec.id_a;
                    o_vertex_third  = r_rec.id_l;
                end
                gtt_pkg::TRI_AL_A_C: begin
                    o_vertex_first  = r_rec.id_al;
                    o_vertex_second = r_rec.id_a;
                    o_vertex_third  = r_rec.id;
                end
                gtt_pkg::TRI_AL_C_L: begin
                    o_vertex_first  = r_rec.id_al;
                    o_vertex_second = r_rec.id;
                    o_vertex_third  = r_rec.id_l;
                end
                gtt_pkg::TRI_A_C_L: begin
                    o_vertex_first  = r_rec.id_a;
                    o_vertex_second = r_rec.id;
                    o_vertex_third  = r_rec.id_l;
                end
                default: begin
                    o_vertex_first = '0;
                end
            endcase
        end
    end

endmodule

>>> sv/grid_threshold_triangulator_top.sv
// An accepted point passes the front's r_s1 registers and the four-entry record queue into the
// back's record register. Throughput: one point per cycle into the front while full is low; the
// result port gives one result per cycle while pop is high, one to three results per queued point.
// Reset: synchronous, active low; clears counters, queue and configuration to defaults.
// The validity line buffer is not cleared; row 0 of each grid writes it before it is used.
// Depends on gtt_pkg, gtt_front, gtt_queue, gtt_back.
module grid_threshold_triangulator_top #(
    parameter int MAX_COLUMNS = gtt_pkg::GTT_MAX_COLUMNS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [gtt_pkg::GTT_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtt_pkg::GTT_CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_a,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_b,
    input  logic                                   i_frame_start,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_kind,
    output logic [gtt_pkg::GTT_ID_W-1:0]           o_vertex_first,
    output logic [gtt_pkg::GTT_ID_W-1:0]           o_vertex_second,
    output logic [gtt_pkg::GTT_ID_W-1:0]           o_vertex_third,
    output logic                                   o_last
);

    gtt_pkg::t_cfg                    r_cfg;
    logic                             q_push;
    gtt_pkg::t_rec                    q_wdata;
    logic                             q_pop;
    gtt_pkg::t_rec                    q_rdata;
    logic                             q_empty;
    logic [gtt_pkg::GTT_QCOUNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= gtt_pkg::GTT_CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (gtt_pkg::t_cfg_idx'(i_cfg_index))
                gtt_pkg::CFG_ROW_LENGTH:       r_cfg.row_length <= i_cfg_data[10:0];
                gtt_pkg::CFG_THRESHOLD_ENABLE: r_cfg.threshold_enable <= i_cfg_data[0];
                gtt_pkg::CFG_TRIANGLE_ENABLE:  r_cfg.triangle_enable <= i_cfg_data[0];
                gtt_pkg::CFG_CONSTRAINT_MASK:  r_cfg.constraint_mask <= i_cfg_data[1:0];
                gtt_pkg::CFG_LOWER_A:          r_cfg.lower_a <= i_cfg_data;
                gtt_pkg::CFG_UPPER_A:          r_cfg.upper_a <= i_cfg_data;
                gtt_pkg::CFG_LOWER_B:          r_cfg.lower_b <= i_cfg_data;
                gtt_pkg::CFG_UPPER_B:          r_cfg.upper_b <= i_cfg_data;
                default:                       r_cfg <= r_cfg;
            endcase
        end
    end

    gtt_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_value_a     (i_value_a),
        .i_value_b     (i_value_b),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .i_q_count     (q_count),
        .o_q_push      (q_push),
        .o_q_rec       (q_wdata)
    );

    gtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    gtt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_vertex_first  (o_vertex_first),
        .o_vertex_second (o_vertex_second),
        .o_vertex_third  (o_vertex_third),
        .o_last          (o_last)
    );

endmodule

>>> test/gtt_result_checker.sv
`timescale 1ns / 1ps
// gtt_result_checker: watches the register, point and result channels of the grid threshold
// triangulator, predicts the vertex and triangle results of every point and compares them.
// Depends on gtt_pkg.
module gtt_result_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [gtt_pkg::GTT_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtt_pkg::GTT_CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                   i_push,
    input  logic                                   i_full,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_a,
    input  logic signed [gtt_pkg::GTT_VALUE_W-1:0] i_value_b,
    input  logic                                   i_frame_start,
    input  logic                                   i_empty,
    input  logic                                   i_pop,
    input  logic                                   i_kind,
    input  logic [gtt_pkg::GTT_ID_W-1:0]           i_vertex_first,
    input  logic [gtt_pkg::GTT_ID_W-1:0]           i_vertex_second,
    input  logic [gtt_pkg::GTT_ID_W-1:0]           i_vertex_third,
    input  logic                                   i_last,
    output int                                     o_mismatches,
    output int                                     o_pending,
    output int                                     o_checked
);

    localparam int MAX_ROWS     = 1024;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic         kind;
        gtt_pkg::t_id first;
        gtt_pkg::t_id second;
        gtt_pkg::t_id third;
        logic         last;
    } t_mesh_result;

    t_mesh_result expected_results[$];

    gtt_pkg::t_cfg cfg;
    logic          line_valid [gtt_pkg::GTT_MAX_COLUMNS];
    logic          prev_valid;
    int unsigned   col_pos;
    int unsigned   row_pos;
    gtt_pkg::t_id  next_id;

    function automatic t_mesh_result make_result(input logic kind,
                                                 input gtt_pkg::t_id f, s, t);
        t_mesh_result r;
        r.kind   = kind;
        r.first  = f;
        r.second = s;
        r.third  = t;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic predict_point(input logic signed [gtt_pkg::GTT_VALUE_W-1:0] va, vb,
                                 input logic fresh);
        int unsigned  span;
        int unsigned  col;
        int           n;
        int           i;
        gtt_pkg::t_id id;
        gtt_pkg::t_id id_l;
        gtt_pkg::t_id id_a;
        gtt_pkg::t_id id_al;
        logic         here;
        logic         left;
        logic         up;
        logic         up_left;
        t_mesh_result batch [3];
        span = 32'(cfg.row_length);
        if (span < 2) span = 2;
        if (span > gtt_pkg::GTT_MAX_COLUMNS) span = gtt_pkg::GTT_MAX_COLUMNS;
        if (fresh) begin
            col_pos    = 0;
            row_pos    = 0;
            next_id    = '0;
            prev_valid = 1'b0;
        end
        if (col_pos >= span) col_pos = 0;
        col  = col_pos;
        id   = next_id;
        here = 1'b1;
        if (cfg.threshold_enable) begin
            if (cfg.constraint_mask[0] &&
                (va < $signed(cfg.lower_a) || va > $signed(cfg.upper_a))) here = 1'b0;
            if (cfg.constraint_mask[1] &&
                (vb < $signed(cfg.lower_b) || vb > $signed(cfg.upper_b))) here = 1'b0;
        end
        n = 0;
        if (here) begin
            batch[n] = make_result(gtt_pkg::KIND_VERTEX, id, '0, '0);
            n++;
        end
        left    = prev_valid;
        up      = line_valid[col];
        up_left = (col > 0) ? line_valid[col-1] : 1'b0;
        if (cfg.triangle_enable && row_pos > 0 && col > 0) begin
            id_l  = id - gtt_pkg::t_id'(1);
            id_a  = id - gtt_pkg::t_id'(span);
            id_al = id_a - gtt_pkg::t_id'(1);
            if (up_left && up && left && here) begin
                batch[n]   = make_result(gtt_pkg::KIND_TRIANGLE, id_al, id_a, id);
                batch[n+1] = make_result(gtt_pkg::KIND_TRIANGLE, id_al, id, id_l);
                n = n + 2;
            end else if (up_left && up && left) begin
                batch[n] = make_result(gtt_pkg::KIND_TRIANGLE, id_al, id_a, id_l);
                n++;
            end else if (up_left && up && here) begin
                batch[n] = make_result(gtt_pkg::KIND_TRIANGLE, id_al, id_a, id);
                n++;
            end else if (up_left && left && here) begin
                batch[n] = make_result(gtt_pkg::KIND_TRIANGLE, id_al, id, id_l);
                n++;
            end else if (up && left && here) begin
                batch[n] = make_result(gtt_pkg::KIND_TRIANGLE, id_a, id, id_l);
                n++;
            end
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (i = 0; i < n; i++) expected_results.push_back(batch[i]);

        if (col > 0) line_valid[col-1] = left;
        prev_valid = here;
        if (col + 1 >= span) begin
            line_valid[col] = here;
            col_pos         = 0;
            if (row_pos < MAX_ROWS - 1) row_pos++;
            prev_valid      = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        next_id = next_id + 1'b1;
    endtask

    task automatic check_result();
        t_mesh_result got;
        t_mesh_result want;
        got      = make_result(i_kind, i_vertex_first, i_vertex_second, i_vertex_third);
        got.last = i_last;
        o_checked++;
        if (expected_results.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_LIMIT)
                $display("unexpected result: kind %0d ids %0d %0d %0d last %0d",
                         got.kind, got.first, got.second, got.third, got.last);
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                o_mismatches++;
                if (o_mismatches <= REPORT_LIMIT) begin
                    $display("result %0d: expected kind %0d ids %0d %0d %0d last %0d,",
                             o_checked, want.kind, want.first, want.second, want.third,
                             want.last);
                    $display("    got kind %0d ids %0d %0d %0d last %0d",
                             got.kind, got.first, got.second, got.third, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg        = gtt_pkg::GTT_CFG_RESET;
            prev_valid = 1'b0;
            col_pos    = 0;
            row_pos    = 0;
            next_id    = '0;
            for (int c = 0; c < gtt_pkg::GTT_MAX_COLUMNS; c++) line_valid[c] = 1'b0;
            expected_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (gtt_pkg::t_cfg_idx'(i_cfg_index))
                    gtt_pkg::CFG_ROW_LENGTH:
                        cfg.row_length = i_cfg_data[gtt_pkg::GTT_ROW_LEN_W-1:0];
                    gtt_pkg::CFG_THRESHOLD_ENABLE: cfg.threshold_enable = i_cfg_data[0];
                    gtt_pkg::CFG_TRIANGLE_ENABLE:  cfg.triangle_enable  = i_cfg_data[0];
                    gtt_pkg::CFG_CONSTRAINT_MASK:  cfg.constraint_mask  = i_cfg_data[1:0];
                    gtt_pkg::CFG_LOWER_A:          cfg.lower_a          = i_cfg_data;
                    gtt_pkg::CFG_UPPER_A:          cfg.upper_a          = i_cfg_data;
                    gtt_pkg::CFG_LOWER_B:          cfg.lower_b          = i_cfg_data;
                    gtt_pkg::CFG_UPPER_B:          cfg.upper_b          = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) check_result();
            if (i_push && !i_full) predict_point(i_value_a, i_value_b, i_frame_start);
        end
        o_pending = expected_results.size();
    end

endmodule

>>> test/grid_threshold_triangulator_top_test.sv
`timescale 1ns / 1ps
// grid_threshold_triangulator_top_test: clock, reset, register settings, paced point stimulus
// and result pops for the grid threshold triangulator; gtt_result_checker does the checking.
// Depends on gtt_pkg, grid_threshold_triangulator_top and gtt_result_checker.
module grid_threshold_triangulator_top_test;

    localparam int                     CYCLE_LIMIT   = 600000;
    localparam int                     SETTLE_CYCLES = 8;
    localparam logic [31:0]            SIGN_BIT      = 32'h8000_0000;
    localparam logic signed [31:0]     VALUE_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0]     VALUE_MAX     = 32'sh7FFF_FFFF;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_wr_en   = 1'b0;
    logic [gtt_pkg::GTT_CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [gtt_pkg::GTT_CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                               push          = 1'b0;
    logic                               full;
    logic signed [31:0]                 i_value_a     = '0;
    logic signed [31:0]                 i_value_b     = '0;
    logic                               i_frame_start = 1'b0;
    logic                               empty;
    logic                               pop           = 1'b0;
    logic                               o_kind;
    gtt_pkg::t_id                       o_vertex_first;
    gtt_pkg::t_id                       o_vertex_second;
    gtt_pkg::t_id                       o_vertex_third;
    logic                               o_last;

    int   mismatches;
    int   pending;
    int   checked;
    logic push_taken     = 1'b0;
    int   cycle_count    = 0;
    int   rx_tick        = 0;
    int   burst_left     = 0;
    int   points_sent    = 0;
    int   settings_used  = 0;

    logic signed [31:0] gen_lower_a;
    logic signed [31:0] gen_upper_a;
    logic signed [31:0] gen_lower_b;
    logic signed [31:0] gen_upper_b;

    grid_threshold_triangulator_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_value_a       (i_value_a),
        .i_value_b       (i_value_b),
        .i_frame_start   (i_frame_start),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_vertex_first  (o_vertex_first),
        .o_vertex_second (o_vertex_second),
        .o_vertex_third  (o_vertex_third),
        .o_last          (o_last)
    );

    gtt_result_checker result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_value_a       (i_value_a),
        .i_value_b       (i_value_b),
        .i_frame_start   (i_frame_start),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_kind          (o_kind),
        .i_vertex_first  (o_vertex_first),
        .i_vertex_second (o_vertex_second),
        .i_vertex_third  (o_vertex_third),
        .i_last          (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        push_taken  <= push && !full;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[8:7])
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= $urandom_range(0, 3) != 0;
            2'd2:    pop <= (rx_tick % 5) != 0 && (rx_tick % 5) != 2;
            default: pop <= $urandom_range(0, 5) == 0;
        endcase
    end

    task automatic cfg_write(input gtt_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [10:0] row_len, input logic thr_on,
                             input logic tri_on, input logic [1:0] mask,
                             input logic [31:0] la, ua, lb, ub);
        wait_drained();
        cfg_write(gtt_pkg::CFG_ROW_LENGTH, {21'd0, row_len});
        cfg_write(gtt_pkg::CFG_THRESHOLD_ENABLE, {31'd0, thr_on});
        cfg_write(gtt_pkg::CFG_TRIANGLE_ENABLE, {31'd0, tri_on});
        cfg_write(gtt_pkg::CFG_CONSTRAINT_MASK, {30'd0, mask});
        cfg_write(gtt_pkg::CFG_LOWER_A, la);
        cfg_write(gtt_pkg::CFG_UPPER_A, ua);
        cfg_write(gtt_pkg::CFG_LOWER_B, lb);
        cfg_write(gtt_pkg::CFG_UPPER_B, ub);
        gen_lower_a = la;
        gen_upper_a = ua;
        gen_lower_b = lb;
        gen_upper_b = ub;
        settings_used++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic push_point(input logic [31:0] a, b, input logic fresh);
        pace_sender();
        push          = 1'b1;
        i_value_a     = a;
        i_value_b     = b;
        i_frame_start = fresh;
        do @(negedge i_clk); while (!push_taken);
        points_sent++;
    endtask

    function automatic logic [31:0] value_for(input logic signed [31:0] lo, hi,
                                              input bit want_in);
        logic [31:0] room;
        logic [31:0] offset;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return lo;
            2:       return hi;
            default: ;
        endcase
        if (lo > hi) return $urandom;
        if (want_in) begin
            room = hi - lo;
            return lo + $urandom_range(0, room);
        end
        if (lo != VALUE_MIN && (hi == VALUE_MAX || $urandom_range(0, 1) == 1)) begin
            room   = (lo ^ SIGN_BIT) - 1;
            offset = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, room);
            return lo - 1 - offset;
        end
        if (hi != VALUE_MAX) begin
            room   = ~(hi ^ SIGN_BIT) - 1;
            offset = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, room);
            return hi + 1 + offset;
        end
        return $urandom;
    endfunction

    task automatic run_points(input int count, input int pct, input bit mid_frames,
                              input bit hold_mid);
        int   k;
        logic fresh;
        for (k = 0; k < count; k++) begin
            if (hold_mid && k == count / 2) wait_drained();
            fresh = (k == 0) || (mid_frames && $urandom_range(0, 59) == 0);
            push_point(value_for(gen_lower_a, gen_upper_a, $urandom_range(0, 99) < pct),
                       value_for(gen_lower_b, gen_upper_b, $urandom_range(0, 99) < pct),
                       fresh);
        end
    endtask

    task automatic random_bounds(output logic [31:0] lo, hi);
        logic signed [31:0] x;
        logic signed [31:0] y;
        x = $urandom;
        y = $urandom;
        case ($urandom_range(0, 5))
            0: begin lo = VALUE_MIN; hi = VALUE_MAX; end
            1: begin lo = -$signed({12'd0, x[19:0]}); hi = {12'd0, y[19:0]}; end
            2: begin lo = x; hi = x; end
            3: begin lo = (x > y) ? x : y; hi = (x > y) ? y : x; end
            4: begin lo = (x < y) ? x : y; hi = (x < y) ? y : x; end
            default: begin lo = VALUE_MAX; hi = VALUE_MIN; end
        endcase
    endtask

    initial begin
        logic [0:14]        shape;
        logic               good;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        la;
        logic [31:0]        ua;
        logic [31:0]        lb;
        logic [31:0]        ub;
        logic [10:0]        row_len;
        logic [1:0]         mask;
        int                 k;
        int                 p;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // 3-column grid: rows hit the full quad and every three-corner triangle
        configure(11'd3, 1'b1, 1'b1, 2'd3,
                  32'hFFFB_0000, 32'h0005_0000, 32'hFFF9_0000, 32'h0007_0000);
        shape = 15'b111_110_011_111_000;
        for (k = 0; k < 17; k++) begin
            good = (k < 15) ? shape[k] : 1'b1;
            if (good) begin
                case (k % 4)
                    0:       begin a = gen_lower_a; b = gen_lower_b; end
                    1:       begin a = gen_upper_a; b = gen_upper_b; end
                    2:       begin a = '0;          b = '0;          end
                    default: begin a = gen_lower_a; b = gen_upper_b; end
                endcase
            end else begin
                case (k % 4)
                    0:       begin a = gen_lower_a - 1; b = '0;              end
                    1:       begin a = gen_upper_a + 1; b = '0;              end
                    2:       begin a = '0;              b = VALUE_MIN;       end
                    default: begin a = VALUE_MAX;       b = gen_upper_b + 1; end
                endcase
            end
            push_point(a, b, k == 0 || k == 16);
        end

        configure(11'd1, 1'b1, 1'b1, 2'd1,
                  32'hFFFF_0000, 32'h0001_0000, VALUE_MIN, VALUE_MAX);
        run_points(40, 80, 1'b1, 1'b0);

        random_bounds(la, ua);
        random_bounds(lb, ub);
        configure(11'd0, 1'b0, 1'b1, 2'd3, la, ua, lb, ub);
        run_points(30, 50, 1'b1, 1'b0);

        for (p = 0; p < 8; p++) begin
            random_bounds(la, ua);
            random_bounds(lb, ub);
            row_len = 11'($urandom_range(2, 12));
            mask    = 2'($urandom_range(0, 3));
            configure(row_len, $urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0, mask,
                      la, ua, lb, ub);
            run_points(38, $urandom_range(55, 95), 1'b1, p == 3);
        end

        configure(11'd5, 1'b1, 1'b0, 2'd3,
                  32'hFFF0_0000, 32'h0010_0000, 32'h0000_8000, VALUE_MAX);
        run_points(30, 70, 1'b1, 1'b0);

        wait_drained();
        $display("Covered %0d points over %0d register settings, %0d results compared,",
                 points_sent, settings_used, checked);
        $display("including every quad shape, clamped short rows and mid-grid frame starts");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/gtt_pkg.sv
sv/gtt_ram.sv
sv/gtt_front.sv
sv/gtt_queue.sv
sv/gtt_back.sv
sv/grid_threshold_triangulator_top.sv
test/gtt_result_checker.sv
test/grid_threshold_triangulator_top_test.sv
